@@ rtl/core/midi_note_stack_saw_oscillator_defines.svh @@
// assertion helpers shared by the core
`ifndef MIDI_NOTE_STACK_SAW_OSCILLATOR_DEFINES_SVH
`define MIDI_NOTE_STACK_SAW_OSCILLATOR_DEFINES_SVH

// same-cycle implication, sampled on the core clock
`define MNSO_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("core check failed");

// next-cycle implication, sampled on the core clock
`define MNSO_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("core check failed");

`endif

@@ rtl/core/mnso_pkg.sv @@
package mnso_pkg;

  // status nibbles of interest
  localparam logic [3:0] STATUS_NOTE_OFF = 4'h8;
  localparam logic [3:0] STATUS_NOTE_ON  = 4'h9;

  localparam logic [7:0] LEVEL_FULL = 8'd255;

  localparam int unsigned STEP_TABLE_LEN = 120;
  localparam logic [6:0]  RESET_NOTE     = 7'd60;

  // phase increment per note, 32-bit phase word
  localparam logic [31:0] STEP_TABLE [STEP_TABLE_LEN] = '{
    32'h00217057, 32'h00236d5d, 32'h002588a8, 32'h0027c404,
    32'h002a215a, 32'h002ca2af, 32'h002f4a26, 32'h00321a04,
    32'h003514b1, 32'h00383cb8, 32'h003b94ca, 32'h003f1fc5,
    32'h0042e0ae, 32'h0046daba, 32'h004b1150, 32'h004f8809,
    32'h005442b4, 32'h0059455e, 32'h005e944c, 32'h00643409,
    32'h006a2963, 32'h00707970, 32'h00772995, 32'h007e3f8a,
    32'h0085c15c, 32'h008db575, 32'h009622a1, 32'h009f1012,
    32'h00a88569, 32'h00b28abc, 32'h00bd2899, 32'h00c86813,
    32'h00d452c6, 32'h00e0f2e0, 32'h00ee532b, 32'h00fc7f15,
    32'h010b82b9, 32'h011b6aeb, 32'h012c4542, 32'h013e2024,
    32'h01510ad3, 32'h01651578, 32'h017a5132, 32'h0190d026,
    32'h01a8a58c, 32'h01c1e5c0, 32'h01dca657, 32'h01f8fe2a,
    32'h02170572, 32'h0236d5d6, 32'h02588a84, 32'h027c4048,
    32'h02a215a6, 32'h02ca2af0, 32'h02f4a264, 32'h0321a04c,
    32'h03514b18, 32'h0383cb81, 32'h03b94cae, 32'h03f1fc55,
    32'h042e0ae5, 32'h046dabac, 32'h04b11508, 32'h04f88091,
    32'h05442b4c, 32'h059455e0, 32'h05e944c9, 32'h06434099,
    32'h06a29630, 32'h07079703, 32'h0772995d, 32'h07e3f8ab,
    32'h085c15ca, 32'h08db5758, 32'h09622a11, 32'h09f10123,
    32'h0a885699, 32'h0b28abc0, 32'h0bd28992, 32'h0c868132,
    32'h0d452c61, 32'h0e0f2e07, 32'h0ee532bb, 32'h0fc7f157,
    32'h10b82b94, 32'h11b6aeb1, 32'h12c45422, 32'h13e20246,
    32'h1510ad33, 32'h16515780, 32'h17a51325, 32'h190d0264,
    32'h1a8a58c3, 32'h1c1e5c0f, 32'h1dca6576, 32'h1f8fe2ae,
    32'h21705728, 32'h236d5d63, 32'h2588a844, 32'h27c4048d,
    32'h2a215a67, 32'h2ca2af01, 32'h2f4a264a, 32'h321a04c9,
    32'h3514b186, 32'h383cb81e, 32'h3b94caed, 32'h3f1fc55c,
    32'h42e0ae51, 32'h46dabac6, 32'h4b115088, 32'h4f88091b,
    32'h5442b4cf, 32'h59455e02, 32'h5e944c95, 32'h64340992,
    32'h6a29630c, 32'h7079703d, 32'h772995db, 32'h7e3f8ab8
  };

  // one incoming request
  typedef struct packed {
    logic       operation;
    logic [7:0] midi_byte;
  } in_req_t;

  // one result
  typedef struct packed {
    logic       sample_valid;
    logic [7:0] dac_level;
    logic [6:0] sounding_note;
    logic [7:0] gate_level;
    logic [4:0] held_count;
  } out_req_t;

endpackage

@@ rtl/core/mnso_ram.sv @@
module mnso_ram #(
  parameter int unsigned WIDTH = 7,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/midi_note_stack_saw_oscillator.sv @@
// channel | direction | handshake                 | payload
// --------+-----------+---------------------------+-------------------------------
// in      | input     | in_valid_i / in_ready_o   | in_req_i  (operation, midi_byte)
// out     | output    | out_valid_o / out_ready_i | out_req_o (sample, dac, note, ...)
//
// a note-off on a non-empty stack passes from accept through the scan, fin and
// done states to the result, the stack ram streaming one entry per cycle through
// its single read port; every other request goes from accept straight to done
// the next request is taken once the result sits in the output register
// reset is immediate: stack entries carry valid bits, so there is no clear pass
// a stalled output holds the core in its result state until the slot frees

`include "midi_note_stack_saw_oscillator_defines.svh"

module midi_note_stack_saw_oscillator #(
  parameter int unsigned DAC_BITS         = 8,
  parameter int unsigned STACK_DEPTH      = 16,
  parameter int unsigned PITCH_TABLE_SIZE = 120
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mnso_pkg::in_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mnso_pkg::out_req_t out_req_o
);

  // stack index and stack count widths
  localparam int unsigned IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_FIN  = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // voice state
  logic [31:0] phase_acc_q, phase_acc_d;
  logic [31:0] phase_step_q, phase_step_d;
  logic [7:0]  level_q, level_d;
  logic [3:0]  status_q, status_d;
  logic        dphase_q, dphase_d;
  logic [6:0]  first_q, first_d;
  logic [CW-1:0] count_q, count_d;
  logic [6:0]  cur_q, cur_d;
  logic        sample_q, sample_d;

  // per-entry valid bits, an invalid entry reads as zero
  logic [STACK_DEPTH-1:0] valid_q, valid_d;

  // release scan
  logic [CW-1:0] issue_q, issue_d;
  logic          pend_q, pend_d;
  logic [IW-1:0] didx_q, didx_d;
  logic          rvalid_q, rvalid_d;
  logic [CW-1:0] rem_q, rem_d;
  logic          skip_q, skip_d;
  logic [6:0]    cap_q, cap_d;

  // output slot
  logic               out_valid_q, out_valid_d;
  mnso_pkg::out_req_t out_q, out_d;

  // ram port
  logic          ram_we, ram_re;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [6:0]    ram_wdata, ram_rdata;

  logic          accept;
  logic [7:0]    mbyte;
  logic          is_off, is_on;
  logic [6:0]    entry;
  logic [CW-1:0] pos;
  logic          hit;
  logic [15:0]   prod;
  logic [CW-1:0] new_count;

  assign accept = in_valid_i && in_ready_o;
  assign mbyte  = in_req_i.midi_byte;
  assign is_off = (status_q == mnso_pkg::STATUS_NOTE_OFF) ||
                  ((status_q == mnso_pkg::STATUS_NOTE_ON) && (mbyte == 8'd0));
  assign is_on  = (status_q == mnso_pkg::STATUS_NOTE_ON) && (mbyte != 8'd0);

  // returned stack entry and its place after the removals seen so far
  assign entry     = rvalid_q ? ram_rdata : 7'd0;
  assign pos       = CW'(didx_q) - rem_q;
  assign hit       = !skip_q && (pos < count_q) && (entry == first_q);
  assign new_count = count_q - CW'(1);

  // saw level times gate, top byte kept
  assign prod = 16'(phase_acc_q[31 -: DAC_BITS]) * 16'(level_q);

  always_comb begin
    state_d      = state_q;
    phase_acc_d  = phase_acc_q;
    phase_step_d = phase_step_q;
    level_d      = level_q;
    status_d     = status_q;
    dphase_d     = dphase_q;
    first_d      = first_q;
    count_d      = count_q;
    cur_d        = cur_q;
    sample_d     = sample_q;
    valid_d      = valid_q;
    issue_d      = issue_q;
    pend_d       = 1'b0;
    didx_d       = didx_q;
    rvalid_d     = rvalid_q;
    rem_d        = rem_q;
    skip_d       = skip_q;
    cap_d        = cap_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    ram_we       = 1'b0;
    ram_waddr    = count_q[IW-1:0];
    ram_wdata    = first_q;
    ram_re       = 1'b0;
    ram_raddr    = issue_q[IW-1:0];

    // downstream takes the pending result
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_DONE;
          if (in_req_i.operation) begin
            // sample tick
            phase_acc_d = phase_acc_q + phase_step_q;
            sample_d    = 1'b1;
          end else begin
            sample_d = 1'b0;
            if (mbyte[7]) begin
              // status byte restarts data pairing
              status_d = mbyte[7:4];
              dphase_d = 1'b0;
            end else if (!dphase_q) begin
              first_d  = mbyte[6:0];
              dphase_d = 1'b1;
            end else begin
              dphase_d = 1'b0;
              if (is_off) begin
                // release with an empty stack is dropped
                if (count_q != '0) begin
                  state_d = S_SCAN;
                  issue_d = '0;
                  rem_d   = '0;
                  skip_d  = 1'b0;
                  cap_d   = '0;
                end
              end else if (is_on) begin
                level_d = mnso_pkg::LEVEL_FULL;
                // push unless the stack is full
                if (count_q < CW'(STACK_DEPTH)) begin
                  ram_we    = 1'b1;
                  ram_waddr = count_q[IW-1:0];
                  ram_wdata = first_q;
                  valid_d[count_q[IW-1:0]] = 1'b1;
                  count_d   = count_q + CW'(1);
                end
                // pitch only rises on a press
                if (first_q > cur_q) begin
                  cur_d = first_q;
                  if ((8'(first_q) < 8'(PITCH_TABLE_SIZE)) &&
                      (8'(first_q) < 8'(mnso_pkg::STEP_TABLE_LEN))) begin
                    phase_step_d = mnso_pkg::STEP_TABLE[first_q];
                  end
                end
              end
            end
          end
        end
      end

      S_SCAN: begin
        // issue reads over the whole stack, one entry per cycle
        if (issue_q < CW'(STACK_DEPTH)) begin
          ram_re    = 1'b1;
          ram_raddr = issue_q[IW-1:0];
          rvalid_d  = valid_q[issue_q[IW-1:0]];
          pend_d    = 1'b1;
          didx_d    = issue_q[IW-1:0];
          issue_d   = issue_q + CW'(1);
        end
        // compact: writes land at or below the entry just read, never on
        // the entry being fetched, so no forwarding is needed
        if (pend_q) begin
          if (hit) begin
            // the entry that slides into this slot is not checked
            rem_d  = rem_q + CW'(1);
            skip_d = 1'b1;
          end else begin
            skip_d    = 1'b0;
            ram_we    = 1'b1;
            ram_waddr = pos[IW-1:0];
            ram_wdata = entry;
            valid_d[pos[IW-1:0]] = 1'b1;
            if (pos == count_q - CW'(2)) begin
              cap_d = entry;
            end
          end
          if (didx_q == IW'(STACK_DEPTH - 1)) begin
            state_d = S_FIN;
          end
        end
      end

      S_FIN: begin
        // vacated top slots read as zero again
        for (int i = 0; i < STACK_DEPTH; i++) begin
          if ((CW+1)'(i) + (CW+1)'(rem_q) >= (CW+1)'(STACK_DEPTH)) begin
            valid_d[i] = 1'b0;
          end
        end
        count_d = new_count;
        if (new_count != '0) begin
          cur_d = cap_q;
        end else begin
          cur_d   = '0;
          level_d = '0;
        end
        state_d = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d         = 1'b1;
          out_d.sample_valid  = sample_q;
          out_d.dac_level     = sample_q ? prod[15:8] : 8'd0;
          out_d.sounding_note = cur_q;
          out_d.gate_level    = level_q;
          out_d.held_count    = 5'(count_q);
          state_d             = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      phase_acc_q  <= '0;
      phase_step_q <= mnso_pkg::STEP_TABLE[mnso_pkg::RESET_NOTE];
      level_q      <= mnso_pkg::LEVEL_FULL;
      status_q     <= mnso_pkg::STATUS_NOTE_OFF;
      dphase_q     <= 1'b0;
      first_q      <= '0;
      count_q      <= '0;
      cur_q        <= '0;
      sample_q     <= 1'b0;
      valid_q      <= '0;
      issue_q      <= '0;
      pend_q       <= 1'b0;
      rem_q        <= '0;
      skip_q       <= 1'b0;
      cap_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      phase_acc_q  <= phase_acc_d;
      phase_step_q <= phase_step_d;
      level_q      <= level_d;
      status_q     <= status_d;
      dphase_q     <= dphase_d;
      first_q      <= first_d;
      count_q      <= count_d;
      cur_q        <= cur_d;
      sample_q     <= sample_d;
      valid_q      <= valid_d;
      issue_q      <= issue_d;
      pend_q       <= pend_d;
      rem_q        <= rem_d;
      skip_q       <= skip_d;
      cap_q        <= cap_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload of the scan pipe and the output slot
  always_ff @(posedge clk_i) begin
    didx_q   <= didx_d;
    rvalid_q <= rvalid_d;
    out_q    <= out_d;
  end

  // held-note stack storage
  mnso_ram #(
    .WIDTH (7),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  // stack never grows past its depth
  `MNSO_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CW'(STACK_DEPTH))
  // returned data always belongs to the entry issued in the cycle before
  `MNSO_ASSERT_IMP(a_scan_pipe, pend_q, CW'(didx_q) == issue_q - CW'(1))
  // finishing a release drops the count by exactly one
  `MNSO_ASSERT_NXT(a_release_count, state_q == S_FIN, count_q == $past(count_q) - CW'(1))
  // a tick never enters the release scan
  `MNSO_ASSERT_IMP(a_scan_no_tick, state_q == S_SCAN, !sample_q)

endmodule
